// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the version chunk directory modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define VCD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define VCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/vcd_pkg.sv -----
// Types and constants of the version chunk directory.
package vcd_pkg;

   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 80;

   localparam logic [1:0] ACT_START  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;

   typedef enum logic [1:0] {
      STS_OK   = 2'd0,
      STS_MISS = 2'd1,
      STS_FULL = 2'd2,
      STS_OVFL = 2'd3
   } status_type;

   // Write broadcast to the cell row.
   typedef struct packed {
      logic        en;
      logic [31:0] ver;
      logic [31:0] end_val;
      logic [1:0]  flags;
   } wr_type;

   // Compare bits held by each cell.
   typedef struct packed {
      logic lt;
      logic eq;
      logic gt0;
   } cmp_type;

   // Readout link between neighboring cells.
   typedef struct packed {
      logic        tok;
      logic [31:0] end_val;
      logic [31:0] prev_val;
      logic [1:0]  flags;
   } link_type;

   // Search unit status toward the controller.
   typedef struct packed {
      logic done;
      logic found;
   } srch_type;

endpackage

// ----- rtl/vcd_cell.sv -----
// One directory cell: holds an entry, compares it, passes the readout link on.
module vcd_cell import vcd_pkg::*; #(
   parameter int unsigned IW = 4,
   parameter int unsigned K  = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  wr_type        wr,
   input  logic [IW-1:0] wr_idx,
   input  logic [31:0]   id,
   input  logic [31:0]   ver0,
   input  logic [31:0]   prev_end,
   output logic [31:0]   end_o,
   output cmp_type       cmp,
   input  logic [IW-1:0] sel,
   input  link_type      link_i,
   output link_type      link_o
);

   logic [31:0] ver_ff, ver_in;
   logic [31:0] end_ff, end_in;
   logic [1:0]  flg_ff, flg_in;
   cmp_type     cmp_ff, cmp_in;
   link_type    link_ff, link_in;
   logic        hit;

   assign hit = wr.en && (wr_idx == IW'(K));

   always_comb begin
      ver_in = hit ? wr.ver : ver_ff;
      end_in = hit ? wr.end_val : end_ff;
      flg_in = hit ? wr.flags : flg_ff;
      cmp_in.lt  = ver_ff < id;
      cmp_in.eq  = ver_ff == id;
      cmp_in.gt0 = ver0 > ver_ff;
      link_in = link_i;
      // insert own entry when the token passes the selected cell
      if (link_i.tok && (sel == IW'(K))) begin
         link_in.end_val  = end_ff;
         link_in.prev_val = prev_end;
         link_in.flags    = flg_ff;
      end
   end

   always_ff @(posedge clock) begin
      ver_ff  <= ver_in;
      end_ff  <= end_in;
      flg_ff  <= flg_in;
      cmp_ff  <= cmp_in;
      link_ff <= link_in;
      if (reset) begin
         link_ff.tok <= 1'b0;
      end
   end

   assign end_o  = end_ff;
   assign cmp    = cmp_ff;
   assign link_o = link_ff;

endmodule

// ----- rtl/vcd_search.sv -----
// Lower-bound binary search over the compare bits of the cell row.
module vcd_search import vcd_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
   input  logic [TABLE_DEPTH-1:0]           lt,
   input  logic [TABLE_DEPTH-1:0]           eq,
   input  logic [TABLE_DEPTH-1:0]           gt0,
   output srch_type                         stat,
   output logic [$clog2(TABLE_DEPTH)-1:0]   pos
);

   `include "assert_macros.svh"

   localparam int unsigned IW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   logic          busy_ff, busy_in;
   logic          desc_ff, desc_in;
   logic [CW-1:0] first_ff, first_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] half, mid, lmid, last, phys;
   logic          done;

   assign last = count - CW'(1);
   assign half = len_ff >> 1;
   assign mid  = first_ff + half;
   // logical position maps to the far end of the row in descending order
   assign lmid = desc_ff ? (last - mid) : mid;
   assign phys = desc_ff ? (last - first_ff) : first_ff;
   assign done = busy_ff && (len_ff == '0);

   always_comb begin
      busy_in  = busy_ff;
      desc_in  = desc_ff;
      first_in = first_ff;
      len_in   = len_ff;
      if (start) begin
         busy_in  = 1'b1;
         first_in = '0;
         len_in   = count;
         desc_in  = (count > CW'(1)) && gt0[last[IW-1:0]];
      end else if (busy_ff && (len_ff != '0)) begin
         if (lt[lmid[IW-1:0]]) begin
            first_in = mid + CW'(1);
            len_in   = len_ff - half - CW'(1);
         end else begin
            len_in = half;
         end
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         desc_ff  <= 1'b0;
         first_ff <= '0;
         len_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         desc_ff  <= desc_in;
         first_ff <= first_in;
         len_ff   <= len_in;
      end
   end

   assign stat.done  = done;
   assign stat.found = done && (first_ff < count) && eq[phys[IW-1:0]];
   assign pos        = phys[IW-1:0];

   `VCD_ASSERT_NEXT(a_len_shrinks, clock, reset, busy_ff && (len_ff != '0), len_ff < $past(len_ff), "search range did not shrink")

endmodule

// ----- rtl/version_chunk_directory_core.sv -----
// Top level of the version chunk directory: controller, cell row and result register.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser action; tdata id, size, flags
//  rsp     | out | rsp_tvalid/rsp_tready | tuser status; tdata index .. count
//
//  Start and append items pass the write and output states before the result is registered.
//  A lookup passes the compare and seed states, then does one search
//  step per cycle, then the readout token walks the whole cell row.
//  One item is worked on at a time; a new item is accepted while the result
//  register still waits for rsp_tready. Reset clears the count and top offset;
//  entries hold no reset value.
module version_chunk_directory_core import vcd_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // version_id[31:0], chunk_size[63:32], is_sparse[64], is_rle[65], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // entry_index[3:0], data_offset[35:4], data_size[67:36], found_sparse[68],
   // found_rle[69], materialized[70], entry_count[75:71], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]            rsp_tuser
);

   `include "assert_macros.svh"

   localparam int unsigned IW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CMP   = 7'b0000010,
      ST_SEED  = 7'b0000100,
      ST_SRCH  = 7'b0001000,
      ST_READ  = 7'b0010000,
      ST_WRITE = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type     state_ff, state_in;
   logic [1:0]    act_ff, act_in;
   logic [31:0]   id_ff, id_in;
   logic [31:0]   size_ff, size_in;
   logic [1:0]    flg_ff, flg_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   top_ff, top_in;
   logic [31:0]   ver0_ff, ver0_in;
   logic [IW-1:0] sel_ff, sel_in;
   logic          launch_ff, launch_in;
   status_type    rstat_ff, rstat_in;
   logic [IW-1:0] ridx_ff, ridx_in;
   logic [31:0]   roff_ff, roff_in;
   logic [31:0]   rsize_ff, rsize_in;
   logic [1:0]    rflg_ff, rflg_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]    rsp_tuser_ff, rsp_tuser_in;

   wr_type        wr;
   logic [IW-1:0] wr_idx;
   logic [32:0]   sum;
   logic          load;
   logic          mat;
   srch_type      stat;
   logic [IW-1:0] pos;
   logic [TABLE_DEPTH-1:0] lt, eq, gt0;
   logic [31:0]   end_w [TABLE_DEPTH];
   cmp_type       cmp_w [TABLE_DEPTH];
   link_type      link_w [TABLE_DEPTH+1];

   assign req_tready = (state_ff == ST_IDLE);
   assign sum  = {1'b0, top_ff} + {1'b0, size_ff};
   assign load = (state_ff == ST_OUT) && (!rsp_tvalid_ff || rsp_tready);
   assign mat  = (rstat_ff == STS_OK) && (ridx_ff == '0);

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      id_in     = id_ff;
      size_in   = size_ff;
      flg_in    = flg_ff;
      count_in  = count_ff;
      top_in    = top_ff;
      ver0_in   = ver0_ff;
      sel_in    = sel_ff;
      launch_in = 1'b0;
      rstat_in  = rstat_ff;
      ridx_in   = ridx_ff;
      roff_in   = roff_ff;
      rsize_in  = rsize_ff;
      rflg_in   = rflg_ff;
      wr        = '0;
      wr_idx    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in  = req_tuser;
               id_in   = req_tdata[31:0];
               size_in = req_tdata[63:32];
               flg_in  = req_tdata[65:64];
               if ((req_tuser == ACT_START) || (req_tuser == ACT_APPEND)) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            state_in = ST_SEED;
         end
         ST_SEED: begin
            state_in = ST_SRCH;
         end
         ST_SRCH: begin
            if (stat.done) begin
               if (stat.found) begin
                  sel_in    = pos;
                  launch_in = 1'b1;
                  state_in  = ST_READ;
               end else begin
                  rstat_in = STS_MISS;
                  ridx_in  = '0;
                  roff_in  = '0;
                  rsize_in = '0;
                  rflg_in  = '0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_READ: begin
            if (link_w[TABLE_DEPTH].tok) begin
               rstat_in = STS_OK;
               ridx_in  = sel_ff;
               roff_in  = link_w[TABLE_DEPTH].prev_val;
               rsize_in = link_w[TABLE_DEPTH].end_val - link_w[TABLE_DEPTH].prev_val;
               rflg_in  = link_w[TABLE_DEPTH].flags;
               state_in = ST_OUT;
            end
         end
         ST_WRITE: begin
            state_in = ST_OUT;
            rstat_in = STS_OK;
            ridx_in  = '0;
            roff_in  = '0;
            rsize_in = '0;
            rflg_in  = '0;
            if (act_ff == ACT_START) begin
               wr.en      = 1'b1;
               wr.ver     = id_ff;
               wr.end_val = size_ff;
               wr.flags   = flg_ff;
               count_in   = CW'(1);
               top_in     = size_ff;
               ver0_in    = id_ff;
               rsize_in   = size_ff;
               rflg_in    = flg_ff;
            end else if (count_ff == CW'(TABLE_DEPTH)) begin
               rstat_in = STS_FULL;
            end else if (sum[32]) begin
               rstat_in = STS_OVFL;
            end else begin
               wr.en      = 1'b1;
               wr.ver     = id_ff;
               wr.end_val = sum[31:0];
               wr.flags   = flg_ff;
               wr_idx     = count_ff[IW-1:0];
               count_in   = count_ff + CW'(1);
               top_in     = sum[31:0];
               if (count_ff == '0) begin
                  ver0_in = id_ff;
               end
               ridx_in  = count_ff[IW-1:0];
               roff_in  = top_ff;
               rsize_in = size_ff;
               rflg_in  = flg_ff;
            end
         end
         ST_OUT: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tuser_in  = rstat_ff;
         rsp_tdata_in  = {4'b0000, 5'(count_ff), mat, rflg_ff, rsize_ff, roff_ff,
                          4'(ridx_ff)};
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      id_ff        <= id_in;
      size_ff      <= size_in;
      flg_ff       <= flg_in;
      ver0_ff      <= ver0_in;
      sel_ff       <= sel_in;
      rstat_ff     <= rstat_in;
      ridx_ff      <= ridx_in;
      roff_ff      <= roff_in;
      rsize_ff     <= rsize_in;
      rflg_ff      <= rflg_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         top_ff        <= '0;
         launch_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         top_ff        <= top_in;
         launch_ff     <= launch_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // readout token enters at cell 0 with no previous end
   always_comb begin
      link_w[0]          = '0;
      link_w[0].tok      = launch_ff;
   end

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      logic [31:0] prev_end;
      if (k == 0) begin : g_first
         assign prev_end = '0;
      end else begin : g_rest
         assign prev_end = end_w[k-1];
      end
      vcd_cell #(
         .IW (IW),
         .K  (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr       (wr),
         .wr_idx   (wr_idx),
         .id       (id_ff),
         .ver0     (ver0_ff),
         .prev_end (prev_end),
         .end_o    (end_w[k]),
         .cmp      (cmp_w[k]),
         .sel      (sel_ff),
         .link_i   (link_w[k]),
         .link_o   (link_w[k+1])
      );
      assign lt[k]  = cmp_w[k].lt;
      assign eq[k]  = cmp_w[k].eq;
      assign gt0[k] = cmp_w[k].gt0;
   end

   vcd_search #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_search (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_SEED),
      .count (count_ff),
      .lt    (lt),
      .eq    (eq),
      .gt0   (gt0),
      .stat  (stat),
      .pos   (pos)
   );

   `VCD_ASSERT_NEXT(a_accept_gap, clock, reset, req_tvalid && req_tready, !req_tready, "item accepted in back-to-back cycles")
   `VCD_ASSERT_NEXT(a_count_hold, clock, reset, state_ff != ST_WRITE, $stable(count_ff), "count changed outside a write")
   `VCD_ASSERT(a_count_range, clock, reset, count_ff <= CW'(TABLE_DEPTH), "count beyond table depth")
   `VCD_ASSERT(a_rsp_from_out, clock, reset, $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_OUT), "result raised outside output state")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the version chunk directory core.
module testbench;
   import vcd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DIR_DEPTH   = 16;
   localparam int unsigned DIR_IW      = $clog2(DIR_DEPTH);
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned DRAIN_WAIT  = 40;
   // Spare action code; the core treats it as a lookup.
   localparam logic [1:0]  ACT_SPARE   = 2'd3;

   typedef struct packed {
      status_type  status;
      logic [3:0]  index;
      logic [31:0] offset;
      logic [31:0] size;
      logic        sparse;
      logic        rle;
      logic        materialized;
      logic [4:0]  count;
   } dir_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = ACT_START;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   // Directory mirror kept by the predictor.
   logic [31:0] dir_version [DIR_DEPTH];
   logic [31:0] dir_end     [DIR_DEPTH];
   logic [1:0]  dir_flags   [DIR_DEPTH];
   int unsigned dir_count = 0;
   logic [31:0] dir_top   = '0;

   dir_result_type awaited_results[$];
   bit          no_idle = 1'b0;
   int unsigned errors = 0;
   int unsigned cycle_count = 0;
   int unsigned action_seen [4] = '{default: 0};
   int unsigned status_seen [4] = '{default: 0};

   version_chunk_directory_core #(.TABLE_DEPTH(DIR_DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run stalled after %0d cycles", $time, cycle_count);
         $display("version_chunk_directory_core: mismatch");
         $finish;
      end
   end

   // Table position of a mirror entry.
   function automatic logic [DIR_IW-1:0] slot(input int unsigned k);
      return DIR_IW'(k);
   endfunction

   // Update the directory mirror with one item and return the result it causes.
   task automatic directory_apply(input logic [1:0] action, input logic [31:0] id,
                                  input logic [31:0] size, input logic sparse,
                                  input logic rle, output dir_result_type r);
      logic [32:0] new_end;
      logic [31:0] probe;
      int unsigned first, len, half, mid, pos;
      bit          desc, found;
      r = '0;
      r.status = STS_OK;
      case (action)
         ACT_START: begin
            dir_version[0] = id;
            dir_end[0]     = size;
            dir_flags[0]   = {rle, sparse};
            dir_count      = 1;
            dir_top        = size;
            r.size   = size;
            r.sparse = sparse;
            r.rle    = rle;
         end
         ACT_APPEND: begin
            new_end = {1'b0, dir_top} + {1'b0, size};
            if (dir_count >= DIR_DEPTH) begin
               r.status = STS_FULL;
            end else if (new_end[32]) begin
               r.status = STS_OVFL;
            end else begin
               pos = dir_count;
               dir_version[slot(pos)] = id;
               dir_end[slot(pos)]     = new_end[31:0];
               dir_flags[slot(pos)]   = {rle, sparse};
               r.index  = pos[3:0];
               r.offset = dir_top;
               r.size   = size;
               r.sparse = sparse;
               r.rle    = rle;
               dir_count = pos + 1;
               dir_top   = new_end[31:0];
            end
         end
         default: begin
            found = 1'b0;
            pos   = 0;
            if (dir_count != 0) begin
               desc  = dir_count > 1 && dir_version[0] > dir_version[slot(dir_count - 1)];
               first = 0;
               len   = dir_count;
               // Lower bound: step right while the probed id is smaller.
               while (len > 0) begin
                  half  = len / 2;
                  mid   = first + half;
                  probe = desc ? dir_version[slot(dir_count - 1 - mid)]
                               : dir_version[slot(mid)];
                  if (probe < id) begin
                     first = mid + 1;
                     len   = len - half - 1;
                  end else begin
                     len = half;
                  end
               end
               if (first < dir_count) begin
                  pos   = desc ? dir_count - 1 - first : first;
                  found = dir_version[slot(pos)] == id;
               end
            end
            if (found) begin
               r.index  = pos[3:0];
               r.offset = (pos == 0) ? 32'd0 : dir_end[slot(pos - 1)];
               r.size   = dir_end[slot(pos)] - r.offset;
               r.sparse = dir_flags[slot(pos)][0];
               r.rle    = dir_flags[slot(pos)][1];
            end else begin
               r.status = STS_MISS;
            end
         end
      endcase
      r.materialized = (r.status == STS_OK) && (r.index == 4'd0);
      r.count = dir_count[4:0];
   endtask

   // Drive one item at the falling edge and hold it until accepted.
   task automatic send_item(input logic [1:0] action, input logic [31:0] id,
                            input logic [31:0] size, input logic sparse, input logic rle);
      int unsigned gap;
      dir_result_type want;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = action;
      req_tdata  = {{(REQ_DATA_W - 66){1'b0}}, rle, sparse, size, id};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      directory_apply(action, id, size, sparse, rle, want);
      awaited_results = {awaited_results, want};
      action_seen[action]++;
      @(negedge clock);
   endtask

   // Mostly small sizes, now and then full width or close to the top.
   function automatic logic [31:0] pick_size();
      int unsigned sel;
      sel = $urandom_range(0, 15);
      if (sel == 0) return 32'hFFFF_FFFF - $urandom_range(0, 16);
      if (sel < 3) return $urandom;
      return $urandom_range(0, 4096);
   endfunction

   // Mostly ids held in the table, some near misses, some anything.
   function automatic logic [31:0] pick_lookup_id();
      logic [31:0] id;
      if (dir_count == 0 || $urandom_range(0, 9) < 3) return $urandom;
      id = dir_version[slot($urandom_range(0, dir_count - 1))];
      if ($urandom_range(0, 5) == 0) id = $urandom_range(0, 1) ? id + 1 : id - 1;
      return id;
   endfunction

   function automatic logic [1:0] pick_lookup_action();
      return ($urandom_range(0, 7) == 0) ? ACT_SPARE : ACT_LOOKUP;
   endfunction

   function automatic logic pick_flag();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      dir_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, tuser 0x%0h tdata 0x%0h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            want = awaited_results.pop_front();
            status_seen[want.status]++;
            compare_field("status",       32'(want.status),       32'(rsp_tuser));
            compare_field("entry_index",  32'(want.index),        32'(rsp_tdata[3:0]));
            compare_field("data_offset",  want.offset,            rsp_tdata[35:4]);
            compare_field("data_size",    want.size,              rsp_tdata[67:36]);
            compare_field("found_sparse", 32'(want.sparse),       32'(rsp_tdata[68]));
            compare_field("found_rle",    32'(want.rle),          32'(rsp_tdata[69]));
            compare_field("materialized", 32'(want.materialized), 32'(rsp_tdata[70]));
            compare_field("entry_count",  32'(want.count),        32'(rsp_tdata[75:71]));
         end
      end
   end

   // Result side: stall a random number of cycles before taking each item.
   initial begin
      int unsigned stall;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 12);
         if (stall != 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic test_directed_cases();
      send_item(ACT_LOOKUP, 32'd0, 32'd0, 1'b0, 1'b0);            // empty table
      send_item(ACT_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_item(ACT_APPEND, 32'd5, 32'h10, 1'b1, 1'b1);           // append to empty
      send_item(ACT_LOOKUP, 32'd5, 32'd0, 1'b0, 1'b0);
      send_item(ACT_START, 32'd0, 32'd0, 1'b0, 1'b0);
      send_item(ACT_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_item(ACT_APPEND, 32'h1234_5678, 32'd1, 1'b1, 1'b1);    // end overflows
      send_item(ACT_APPEND, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b1);    // end exactly at max
      send_item(ACT_LOOKUP, 32'd0, 32'd0, 1'b0, 1'b0);
      send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0);
      send_item(ACT_LOOKUP, 32'h7FFF_FFFF, 32'd0, 1'b0, 1'b0);
      // Descending ids.
      send_item(ACT_START, 32'd1000, 32'h100, 1'b0, 1'b1);
      send_item(ACT_APPEND, 32'd900, 32'h20, 1'b1, 1'b0);
      send_item(ACT_APPEND, 32'd800, 32'h30, 1'b0, 1'b0);
      send_item(ACT_LOOKUP, 32'd900, 32'd0, 1'b0, 1'b0);
      send_item(ACT_LOOKUP, 32'd1000, 32'd0, 1'b0, 1'b0);
      send_item(ACT_SPARE, 32'd800, 32'd0, 1'b0, 1'b0);
      send_item(ACT_LOOKUP, 32'd850, 32'd0, 1'b0, 1'b0);
      // Duplicate and unsorted ids.
      send_item(ACT_START, 32'd7, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_item(ACT_APPEND, 32'd7, 32'd0, 1'b0, 1'b0);
      send_item(ACT_LOOKUP, 32'd7, 32'd0, 1'b0, 1'b0);
      send_item(ACT_APPEND, 32'd3, 32'd0, 1'b1, 1'b0);
      send_item(ACT_LOOKUP, 32'd3, 32'd0, 1'b0, 1'b0);
      send_item(ACT_LOOKUP, 32'd7, 32'd0, 1'b0, 1'b0);
   endtask

   // Fill every slot, push past the end, then find each entry.
   task automatic test_fill_table(input bit descending);
      logic [31:0] id;
      int unsigned k;
      id = descending ? $urandom_range(32'h8000_0000, 32'hFFFF_FFFF)
                      : $urandom_range(0, 32'h7FFF_FFFF);
      send_item(ACT_START, id, $urandom_range(0, 255), pick_flag(), pick_flag());
      for (k = 1; k < DIR_DEPTH + 2; k++) begin
         id = descending ? id - $urandom_range(1, 1000) : id + $urandom_range(1, 1000);
         send_item(ACT_APPEND, id, $urandom_range(0, 255), pick_flag(), pick_flag());
      end
      for (k = 0; k < dir_count; k++)
         send_item(pick_lookup_action(), dir_version[slot(k)], $urandom, pick_flag(),
                   pick_flag());
      send_item(ACT_LOOKUP, $urandom, $urandom, 1'b0, 1'b0);
   endtask

   // Well-formed blocks with random content, mixed with loose items.
   task automatic test_random_blocks(input int unsigned budget);
      int unsigned sent, n, k;
      logic [31:0] id, step;
      bit          desc;
      sent = 0;
      while (sent < budget) begin
         no_idle = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 9) < 7) begin
            id   = $urandom;
            desc = pick_flag();
            send_item(ACT_START, id, pick_size(), pick_flag(), pick_flag());
            n = $urandom_range(0, 17);
            for (k = 0; k < n; k++) begin
               // Occasionally repeat an id or take a huge step that wraps.
               case ($urandom_range(0, 9))
                  0:       step = 0;
                  1:       step = $urandom;
                  default: step = $urandom_range(1, 1 << 16);
               endcase
               id = desc ? id - step : id + step;
               send_item(ACT_APPEND, id, pick_size(), pick_flag(), pick_flag());
            end
            sent += n + 1;
            n = $urandom_range(2, 8);
            for (k = 0; k < n; k++)
               send_item(pick_lookup_action(), pick_lookup_id(), $urandom,
                         pick_flag(), pick_flag());
            sent += n;
         end else begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++)
               send_item(2'($urandom_range(0, 3)), pick_lookup_id(), pick_size(),
                         pick_flag(), pick_flag());
            sent += n;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      no_idle = 1'b1;
      test_fill_table(1'b0);
      no_idle = 1'b0;
      test_fill_table(1'b1);
      test_random_blocks(300);
      req_tvalid = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Items: %0d start, %0d append, %0d lookup (%0d with the spare code)",
               action_seen[ACT_START], action_seen[ACT_APPEND],
               action_seen[ACT_LOOKUP] + action_seen[ACT_SPARE], action_seen[ACT_SPARE]);
      $display("Results: %0d ok, %0d not found, %0d table full, %0d offset overflow",
               status_seen[STS_OK], status_seen[STS_MISS], status_seen[STS_FULL],
               status_seen[STS_OVFL]);
      if (errors == 0) begin
         $display("version_chunk_directory_core: match");
      end else begin
         $display("version_chunk_directory_core: mismatch");
      end
      $finish;
   end

endmodule
